FILE: sv/bmsf_pkg.sv
`default_nettype none
package bmsf_pkg;

  localparam int AREA_W = 28;
  localparam int MOM_W  = 38;
  localparam int CM_W   = 46;
  localparam int XY_W   = 47;
  localparam int OP_W   = 48;
  localparam int HALF_W = 24;
  localparam int SQ_W   = 96;
  localparam int Z_W    = 34;
  localparam int CRD_W  = 64;
  localparam int MX_W   = 60;
  localparam int ECC_W  = 16;
  localparam int Q15_W  = 15;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;

  localparam int CORDIC_STEPS = 31;
  localparam int DIV_STEPS    = MOM_W;

  localparam longint HALF_PI_Q30    = 64'sd1686629713;
  localparam longint QUARTER_PI_Q30 = 64'sd843314857;

  localparam logic [ECC_W-1:0] ECC_ONE = 16'd16384;

  localparam logic [AREA_W-1:0] MIN_AREA_RST = 28'd70000;
  localparam logic [AREA_W-1:0] MAX_AREA_RST = 28'd50000000;

  localparam logic REG_MIN_AREA = 1'b0;
  localparam logic REG_MAX_AREA = 1'b1;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bmsf_if.sv
`default_nettype none
interface bmsf_in_if;
  logic                              valid;
  logic                              ready;
  logic [bmsf_pkg::AREA_W-1:0]       area_moment;
  logic [bmsf_pkg::MOM_W-1:0]        x_moment;
  logic [bmsf_pkg::MOM_W-1:0]        y_moment;
  logic [bmsf_pkg::CM_W-1:0]         central_xx;
  logic [bmsf_pkg::CM_W-1:0]         central_yy;
  logic signed [bmsf_pkg::XY_W-1:0]  central_xy;

  modport source (output valid, area_moment, x_moment, y_moment, central_xx, central_yy,
                  central_xy, input ready);
  modport sink (input valid, area_moment, x_moment, y_moment, central_xx, central_yy,
                central_xy, output ready);
endinterface

interface bmsf_out_if #(
  parameter int COORD_BITS      = 10,
  parameter int ANGLE_FRAC_BITS = 13
);
  logic                              valid;
  logic                              ready;
  logic                              presence;
  logic signed [COORD_BITS:0]        centroid_x;
  logic signed [COORD_BITS:0]        centroid_y;
  logic signed [ANGLE_FRAC_BITS+1:0] orientation;
  logic signed [bmsf_pkg::ECC_W-1:0] eccentricity;
  logic                              eccentricity_valid;

  modport source (output valid, presence, centroid_x, centroid_y, orientation, eccentricity,
                  eccentricity_valid, input ready);
  modport sink (input valid, presence, centroid_x, centroid_y, orientation, eccentricity,
                eccentricity_valid, output ready);
endinterface
`default_nettype wire

FILE: sv/bmsf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bmsf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bmsf_pkg::MOM_W-1:0]    dividend_i,
  input  wire logic [bmsf_pkg::AREA_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [bmsf_pkg::MOM_W-1:0]         quotient_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [5:0]                    cnt_q;
  logic [bmsf_pkg::AREA_W-1:0]   rem_q;
  logic [bmsf_pkg::MOM_W-1:0]    num_q;
  logic [bmsf_pkg::AREA_W:0]     rem_sh;
  logic [bmsf_pkg::AREA_W:0]     rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, num_q[bmsf_pkg::MOM_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = (rem_sh >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        num_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[bmsf_pkg::AREA_W-1:0] : rem_sh[bmsf_pkg::AREA_W-1:0];
        num_q <= {num_q[bmsf_pkg::MOM_W-2:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(bmsf_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule
`default_nettype wire

FILE: sv/blob_moment_shape_features.sv
// Shape features of one foreground blob from its image moments.
// Items arrive on in_i (valid/ready); a transfer carries the area, first and
// second central moments of one mask frame. Each item gives exactly one
// transfer on out_o: presence flag, held centroid, orientation (signed, with
// ANGLE_FRAC_BITS fraction bits) and the eccentricity term in Q1.14 with its
// valid flag. min_area and max_area are written over the APB port.
// Each item passes through two 38-step restoring divisions for the centroid
// (skipped for zero area), 12 partial products of a 24x24 multiplier for the
// three squares, a 15-step division for eccentricity, a normalizing shift of
// up to 58 single-bit steps and a 31-step CORDIC. The shortest path is taken
// for zero area, zero diagonal sum and zero mixed moment.
// The sequencer handles one item at a time; the next item can be taken in the
// cycle after the result is loaded.
// in_i.ready is high only while the sequencer is idle; the finished result
// sits in an output register, so a new item is taken while the previous
// result still waits for a stalled receiver. A second result waits inside
// until the output register frees up.
// Reset sets the area bounds to 70000 and 50000000, empties the output
// register and sets the held centroid to minus one.
`default_nettype none
module blob_moment_shape_features #(
  parameter int COORD_BITS      = 10,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bmsf_in_if.sink                            in_i,
  bmsf_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bmsf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bmsf_pkg::CFG_W-1:0]    pwdata,
  output logic [bmsf_pkg::CFG_W-1:0]         prdata,
  output logic                               pready
);

  localparam int ZW = bmsf_pkg::Z_W;
  localparam int CW = COORD_BITS + 1;
  localparam int OW = ANGLE_FRAC_BITS + 2;

  // Rounded angle limits at the output scale.
  localparam logic signed [ZW-1:0] ORI_MAX = ZW'((bmsf_pkg::HALF_PI_Q30 +
      (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS));
  localparam logic signed [ZW-1:0] QPI = ZW'((bmsf_pkg::QUARTER_PI_Q30 +
      (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS));
  localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(64'sd1 <<< (30 - ANGLE_FRAC_BITS));
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(bmsf_pkg::HALF_PI_Q30);
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIVX = 4'd1;
  localparam logic [3:0] ST_DIVY = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ECC0 = 4'd4;
  localparam logic [3:0] ST_ECC1 = 4'd5;
  localparam logic [3:0] ST_ECC  = 4'd6;
  localparam logic [3:0] ST_ECCF = 4'd7;
  localparam logic [3:0] ST_ORI0 = 4'd8;
  localparam logic [3:0] ST_NORM = 4'd9;
  localparam logic [3:0] ST_QUAD = 4'd10;
  localparam logic [3:0] ST_CORD = 4'd11;
  localparam logic [3:0] ST_ORIF = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  // Configuration registers.
  logic [bmsf_pkg::AREA_W-1:0] min_area_q;
  logic [bmsf_pkg::AREA_W-1:0] max_area_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bmsf_pkg::REG_MAX_AREA) ?
                  bmsf_pkg::CFG_W'(max_area_q) : bmsf_pkg::CFG_W'(min_area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= bmsf_pkg::MIN_AREA_RST;
      max_area_q <= bmsf_pkg::MAX_AREA_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == bmsf_pkg::REG_MIN_AREA) begin
        min_area_q <= pwdata[bmsf_pkg::AREA_W-1:0];
      end else begin
        max_area_q <= pwdata[bmsf_pkg::AREA_W-1:0];
      end
    end
  end

  // Sequencer and datapath registers.
  logic [3:0]                          state_q;
  logic [5:0]                          cnt_q;
  logic                                in_acc;
  logic [bmsf_pkg::AREA_W-1:0]         area_q;
  logic [bmsf_pkg::MOM_W-1:0]          m10_q;
  logic [bmsf_pkg::MOM_W-1:0]          m01_q;
  logic signed [bmsf_pkg::XY_W-1:0]    mu11_q;
  logic signed [bmsf_pkg::XY_W-1:0]    d_q;
  logic [bmsf_pkg::XY_W-1:0]           s_q;
  logic                                pres_q;
  logic signed [CW-1:0]                hold_x_q;
  logic signed [CW-1:0]                hold_y_q;

  // Squares and the eccentricity divider.
  logic [bmsf_pkg::SQ_W-1:0]           sqa_q, sqb_q, sqc_q;
  logic [2*bmsf_pkg::HALF_W-1:0]       pp_q;
  logic [1:0]                          pp_sh_q;
  logic [1:0]                          pp_sel_q;
  logic                                pp_v_q;
  logic [bmsf_pkg::SQ_W-1:0]           n_q;
  logic                                neg_q;
  logic [bmsf_pkg::Q15_W-1:0]          q15_q;
  logic signed [bmsf_pkg::ECC_W-1:0]   ecc_q;
  logic                                eval_q;

  // CORDIC.
  logic signed [bmsf_pkg::CRD_W-1:0]   x_q, y_q;
  logic [bmsf_pkg::MX_W-1:0]           mx_q;
  logic signed [ZW-1:0]                z_q;
  logic signed [OW-1:0]                ori_q;

  // Output register.
  logic                                ov_q;
  logic                                o_pres_q;
  logic signed [CW-1:0]                o_cx_q, o_cy_q;
  logic signed [OW-1:0]                o_ori_q;
  logic signed [bmsf_pkg::ECC_W-1:0]   o_ecc_q;
  logic                                o_eval_q;

  // Divider shared by both centroid coordinates.
  logic                                div_start_q;
  logic                                div_done;
  logic [bmsf_pkg::MOM_W-1:0]          div_q;

  bmsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ((state_q == ST_DIVY) ? m01_q : m10_q),
    .divisor_i  (area_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Combinational helpers.
  logic signed [bmsf_pkg::XY_W-1:0]    d_in;
  logic [bmsf_pkg::XY_W-1:0]           ad_w;
  logic [bmsf_pkg::XY_W-1:0]           mag11_w;
  logic [bmsf_pkg::OP_W-1:0]           am_w;
  logic [bmsf_pkg::OP_W-1:0]           mop;
  logic [bmsf_pkg::HALF_W-1:0]         mha, mhb;
  logic [bmsf_pkg::SQ_W-1:0]           pp_ext;
  logic [bmsf_pkg::SQ_W-1:0]           nsh, nsub;
  logic [bmsf_pkg::ECC_W-1:0]          qr;
  logic signed [bmsf_pkg::CRD_W-1:0]   dx, dy;
  logic [4:0]                          ci;
  logic signed [ZW-1:0]                zr;
  logic [CW-1:0]                       qsat;

  assign d_in    = $signed({1'b0, in_i.central_xx}) - $signed({1'b0, in_i.central_yy});
  assign ad_w    = d_q[bmsf_pkg::XY_W-1] ? 47'(-d_q) : 47'(d_q);
  assign mag11_w = mu11_q[bmsf_pkg::XY_W-1] ? 47'(-mu11_q) : 47'(mu11_q);
  assign am_w    = {mag11_w, 1'b0};

  // Operand of the current square: |d|, 2|mu11| or the sum of the diagonals.
  always_comb begin
    unique case (cnt_q[3:2])
      2'd0:    mop = bmsf_pkg::OP_W'(ad_w);
      2'd1:    mop = am_w;
      default: mop = bmsf_pkg::OP_W'(s_q);
    endcase
  end
  assign mha = cnt_q[1] ? mop[2*bmsf_pkg::HALF_W-1:bmsf_pkg::HALF_W]
                        : mop[bmsf_pkg::HALF_W-1:0];
  assign mhb = cnt_q[0] ? mop[2*bmsf_pkg::HALF_W-1:bmsf_pkg::HALF_W]
                        : mop[bmsf_pkg::HALF_W-1:0];

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_ext = bmsf_pkg::SQ_W'(pp_q);
      2'd1:    pp_ext = bmsf_pkg::SQ_W'(pp_q) << bmsf_pkg::HALF_W;
      default: pp_ext = bmsf_pkg::SQ_W'(pp_q) << (2 * bmsf_pkg::HALF_W);
    endcase
  end

  assign nsh  = n_q << 1;
  assign nsub = nsh - sqc_q;
  assign qr   = (bmsf_pkg::ECC_W'(q15_q) + 16'd1) >> 1;

  assign ci = cnt_q[4:0];
  assign dx = y_q >>> ci;
  assign dy = x_q >>> ci;
  assign zr = (z_q + ROUND_ADD) >>> (31 - ANGLE_FRAC_BITS);

  assign qsat = (div_q[bmsf_pkg::MOM_W-1:COORD_BITS] != '0) ? {1'b0, CMAX}
                                                            : {1'b0, div_q[COORD_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_start_q <= 1'b0;
      hold_x_q    <= '1;
      hold_y_q    <= '1;
      pp_v_q      <= 1'b0;
      ov_q        <= 1'b0;
      area_q      <= '0;
      m10_q       <= '0;
      m01_q       <= '0;
      mu11_q      <= '0;
      d_q         <= '0;
      s_q         <= '0;
      pres_q      <= 1'b0;
      sqa_q       <= '0;
      sqb_q       <= '0;
      sqc_q       <= '0;
      pp_q        <= '0;
      pp_sh_q     <= '0;
      pp_sel_q    <= '0;
      n_q         <= '0;
      neg_q       <= 1'b0;
      q15_q       <= '0;
      ecc_q       <= '0;
      eval_q      <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      mx_q        <= '0;
      z_q         <= '0;
      ori_q       <= '0;
      o_pres_q    <= 1'b0;
      o_cx_q      <= '0;
      o_cy_q      <= '0;
      o_ori_q     <= '0;
      o_ecc_q     <= '0;
      o_eval_q    <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end

      // Partial products are added into their square in the cycle after they are formed.
      pp_v_q <= 1'b0;
      if (pp_v_q) begin
        unique case (pp_sel_q)
          2'd0:    sqa_q <= sqa_q + pp_ext;
          2'd1:    sqb_q <= sqb_q + pp_ext;
          default: sqc_q <= sqc_q + pp_ext;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            area_q <= in_i.area_moment;
            m10_q  <= in_i.x_moment;
            m01_q  <= in_i.y_moment;
            mu11_q <= in_i.central_xy;
            d_q    <= d_in;
            s_q    <= {1'b0, in_i.central_xx} + {1'b0, in_i.central_yy};
            pres_q <= (in_i.area_moment > min_area_q) && (in_i.area_moment < max_area_q);
            sqa_q  <= '0;
            sqb_q  <= '0;
            sqc_q  <= '0;
            cnt_q  <= '0;
            if (in_i.area_moment != '0) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIVX;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            hold_x_q    <= qsat;
            div_start_q <= 1'b1;
            state_q     <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            hold_y_q <= qsat;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_q == 6'd12) begin
            state_q <= ST_ECC0;
          end else begin
            pp_q     <= mha * mhb;
            pp_sh_q  <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
            pp_sel_q <= cnt_q[3:2];
            pp_v_q   <= 1'b1;
            cnt_q    <= cnt_q + 6'd1;
          end
        end
        ST_ECC0: begin
          if (s_q == '0) begin
            ecc_q   <= '0;
            eval_q  <= 1'b0;
            state_q <= ST_ORI0;
          end else begin
            neg_q   <= (sqa_q < sqb_q);
            n_q     <= (sqa_q < sqb_q) ? (sqb_q - sqa_q) : (sqa_q - sqb_q);
            state_q <= ST_ECC1;
          end
        end
        ST_ECC1: begin
          cnt_q <= '0;
          if (n_q >= sqc_q) begin
            // A magnitude of one or more saturates: all ones rounds up to ECC_ONE.
            q15_q   <= '1;
            state_q <= ST_ECCF;
          end else begin
            q15_q   <= '0;
            state_q <= ST_ECC;
          end
        end
        ST_ECC: begin
          n_q   <= (nsh >= sqc_q) ? nsub : nsh;
          q15_q <= {q15_q[bmsf_pkg::Q15_W-2:0], (nsh >= sqc_q)};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(bmsf_pkg::Q15_W - 1)) begin
            state_q <= ST_ECCF;
          end
        end
        ST_ECCF: begin
          ecc_q   <= neg_q ? $signed(-qr) : $signed(qr);
          eval_q  <= 1'b1;
          state_q <= ST_ORI0;
        end
        ST_ORI0: begin
          if (mu11_q == '0) begin
            ori_q   <= '0;
            state_q <= ST_DONE;
          end else if (d_q == '0) begin
            ori_q   <= mu11_q[bmsf_pkg::XY_W-1] ? OW'(-QPI) : OW'(QPI);
            state_q <= ST_DONE;
          end else begin
            x_q     <= bmsf_pkg::CRD_W'(d_q);
            y_q     <= bmsf_pkg::CRD_W'($signed({mu11_q, 1'b0}));
            mx_q    <= (bmsf_pkg::OP_W'(ad_w) > am_w) ? bmsf_pkg::MX_W'(ad_w)
                                                      : bmsf_pkg::MX_W'(am_w);
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          // Scale the vector up until its larger component reaches 2^59.
          if (mx_q[bmsf_pkg::MX_W-1]) begin
            state_q <= ST_QUAD;
          end else begin
            x_q  <= x_q <<< 1;
            y_q  <= y_q <<< 1;
            mx_q <= mx_q << 1;
          end
        end
        ST_QUAD: begin
          cnt_q   <= '0;
          state_q <= ST_CORD;
          if (x_q < 0) begin
            if (y_q > 0) begin
              x_q <= y_q;
              y_q <= -x_q;
              z_q <= HALF_PI_Z;
            end else begin
              x_q <= -y_q;
              y_q <= x_q;
              z_q <= -HALF_PI_Z;
            end
          end else begin
            z_q <= '0;
          end
        end
        ST_CORD: begin
          if (y_q > 0) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + bmsf_pkg::atan_step(ci);
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - bmsf_pkg::atan_step(ci);
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(bmsf_pkg::CORDIC_STEPS - 1)) begin
            state_q <= ST_ORIF;
          end
        end
        ST_ORIF: begin
          if (zr > ORI_MAX) begin
            ori_q <= OW'(ORI_MAX);
          end else if (zr < -ORI_MAX) begin
            ori_q <= OW'(-ORI_MAX);
          end else begin
            ori_q <= OW'(zr);
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!ov_q || out_o.ready) begin
            ov_q     <= 1'b1;
            o_pres_q <= pres_q;
            o_cx_q   <= hold_x_q;
            o_cy_q   <= hold_y_q;
            o_ori_q  <= ori_q;
            o_ecc_q  <= ecc_q;
            o_eval_q <= eval_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid              = ov_q;
  assign out_o.presence           = o_pres_q;
  assign out_o.centroid_x         = o_cx_q;
  assign out_o.centroid_y         = o_cy_q;
  assign out_o.orientation        = o_ori_q;
  assign out_o.eccentricity       = o_ecc_q;
  assign out_o.eccentricity_valid = o_eval_q;

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input reopened right after an accepted item");

  // An undefined eccentricity is reported as zero.
  a_ecc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.eccentricity_valid) |-> (out_o.eccentricity == '0))
    else $error("eccentricity nonzero while flagged invalid");

  // The eccentricity term stays within plus or minus one.
  a_ecc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.eccentricity <= $signed(bmsf_pkg::ECC_ONE) &&
                     out_o.eccentricity >= -$signed(bmsf_pkg::ECC_ONE)))
    else $error("eccentricity out of range");

  // The orientation stays within a quarter turn.
  a_ori_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.orientation <= ORI_MAX && out_o.orientation >= -ORI_MAX))
    else $error("orientation out of range");

  // A new result is loaded only when the output register is free or drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("pending result dropped");

endmodule
`default_nettype wire

FILE: bench/blob_moment_shape_features_test.sv
`default_nettype none
module blob_moment_shape_features_test;
  import bmsf_pkg::*;

  localparam int CB = 10;
  localparam int AF = 13;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam logic [ADDR_W-1:0] ADDR_MIN_AREA = ADDR_W'(4 * REG_MIN_AREA);
  localparam logic [ADDR_W-1:0] ADDR_MAX_AREA = ADDR_W'(4 * REG_MAX_AREA);

  // Arctangent of 2^-i in Q30 radians for the first ten rotations; past that
  // the angle is close enough to 2^-i itself.
  localparam longint ATAN_Q30 [10] = '{843314857, 497837829, 263043837, 133525159,
                                       67021687, 33543516, 16775851, 8388437,
                                       4194283, 2097149};

  typedef struct {
    logic [AREA_W-1:0]       area;
    logic [MOM_W-1:0]        m10;
    logic [MOM_W-1:0]        m01;
    logic [CM_W-1:0]         mu20;
    logic [CM_W-1:0]         mu02;
    logic signed [XY_W-1:0]  mu11;
  } frame_moments_t;

  typedef struct {
    logic                    presence;
    logic signed [CB:0]      cx;
    logic signed [CB:0]      cy;
    logic signed [AF+1:0]    ori;
    logic signed [ECC_W-1:0] ecc;
    logic                    ecc_ok;
  } blob_shape_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  bmsf_in_if in_bus ();
  bmsf_out_if #(.COORD_BITS(CB), .ANGLE_FRAC_BITS(AF)) out_bus ();

  blob_moment_shape_features #(.COORD_BITS(CB), .ANGLE_FRAC_BITS(AF)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copies of the area bounds and the held centroid.
  logic [AREA_W-1:0] bound_lo = MIN_AREA_RST;
  logic [AREA_W-1:0] bound_hi = MAX_AREA_RST;
  logic signed [CB:0] held_cx = -1;
  logic signed [CB:0] held_cy = -1;

  frame_moments_t frames_to_send[$];
  blob_shape_t    shapes_due[$];
  frame_moments_t frame_on_bus;
  int  errors = 0;
  int  cycle_count = 0;
  int  stall_cycles = 0;

  // Vectoring CORDIC: returns atan2(y, x) in Q30 radians. The vector is first
  // scaled so that its larger component reaches 2^59, and a vector in the left
  // half plane is turned by a quarter turn before the rotations start.
  function automatic longint axis_angle_q30(input longint x, input longint y);
    longint mx, my, t, dx, dy, z;
    int k;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    if (my > mx) mx = my;
    k = 0;
    z = 0;
    while (mx < (64'sd1 <<< 59)) begin
      mx = mx <<< 1;
      k++;
    end
    x = x <<< k;
    y = y <<< k;
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q30;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += (i < 10) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
      end else begin
        x -= dx;
        y += dy;
        z -= (i < 10) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
      end
    end
    return z;
  endfunction

  // Expected shape features of one frame; also updates the held centroid.
  function automatic blob_shape_t shape_of(input frame_moments_t f);
    blob_shape_t r;
    longint d, mu11, ori, ori_max, qpi, qx, qy, z;
    logic [127:0] a, b, c, n;
    logic [63:0] ad, am, s;
    logic [15:0] q15;
    longint q;
    logic neg;
    mu11 = longint'(f.mu11);
    d = longint'(f.mu20) - longint'(f.mu02);
    s = 64'(f.mu20) + 64'(f.mu02);
    ori_max = (HALF_PI_Q30 + (64'sd1 <<< (29 - AF))) >>> (30 - AF);
    qpi = (QUARTER_PI_Q30 + (64'sd1 <<< (29 - AF))) >>> (30 - AF);
    ori = 0;
    q = 0;

    if (f.area != 0) begin
      qx = longint'(64'(f.m10) / 64'(f.area));
      qy = longint'(64'(f.m01) / 64'(f.area));
      held_cx = (qx > (2 ** CB - 1)) ? (2 ** CB - 1) : qx;
      held_cy = (qy > (2 ** CB - 1)) ? (2 ** CB - 1) : qy;
    end

    // A zero mixed moment pins the angle to zero; equal diagonal moments give
    // a quarter of pi with the sign of the mixed moment.
    if (mu11 != 0) begin
      if (d == 0) begin
        ori = (mu11 > 0) ? qpi : -qpi;
      end else begin
        z = axis_angle_q30(d, 2 * mu11);
        ori = (z + (64'sd1 <<< (30 - AF))) >>> (31 - AF);
        if (ori > ori_max) ori = ori_max;
        if (ori < -ori_max) ori = -ori_max;
      end
    end

    // Elongation: exact quotient, saturating at one, rounded half away from
    // zero. A zero denominator leaves the term at zero and drops the flag.
    r.ecc_ok = (s != 0);
    if (s != 0) begin
      ad = (d < 0) ? 64'(-d) : 64'(d);
      am = 64'((mu11 < 0) ? -mu11 : mu11) << 1;
      a = 128'(ad) * 128'(ad);
      b = 128'(am) * 128'(am);
      c = 128'(s) * 128'(s);
      neg = (a < b);
      n = neg ? b - a : a - b;
      if (n >= c) begin
        q = ECC_ONE;
      end else begin
        q15 = 0;
        for (int i = 0; i < Q15_W; i++) begin
          n = n << 1;
          q15 = q15 << 1;
          if (n >= c) begin
            n = n - c;
            q15[0] = 1'b1;
          end
        end
        q = (longint'(q15) + 1) >>> 1;
      end
      if (neg) q = -q;
    end

    r.presence = (f.area > bound_lo) && (f.area < bound_hi);
    r.cx = held_cx;
    r.cy = held_cy;
    r.ori = ori[AF+1:0];
    r.ecc = q[ECC_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value of a random bit length, so that small and large moments
  // are both common.
  function automatic logic [63:0] rand_bits(input int w);
    return rand64() >> (64 - $urandom_range(0, w));
  endfunction

  function automatic frame_moments_t random_frame();
    frame_moments_t f;
    logic [63:0] area, sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      // A plausible frame: centroid mostly inside the image, moments of
      // arbitrary size, and now and then an area right at a bound.
      case ($urandom_range(0, 4))
        0: area = 64'(bound_lo) + $urandom_range(0, 2) - 1;
        1: area = 64'(bound_hi) + $urandom_range(0, 2) - 1;
        2: area = $urandom_range(0, 20);
        default: area = rand_bits(AREA_W);
      endcase
      f.area = area[AREA_W-1:0];
      area = 64'(f.area);
      f.m10 = MOM_W'(area * $urandom_range(0, 1100) + ((area == 0) ? 0 : rand64() % area));
      f.m01 = MOM_W'(area * $urandom_range(0, 1100) + ((area == 0) ? 0 : rand64() % area));
      f.mu20 = CM_W'(rand_bits(CM_W));
      f.mu02 = ($urandom_range(0, 9) == 0) ? f.mu20 : CM_W'(rand_bits(CM_W));
      f.mu11 = ($urandom_range(0, 9) == 0) ? '0 : XY_W'(rand_bits(XY_W - 1));
      if ($urandom_range(0, 1)) f.mu11 = -f.mu11;
    end else begin
      f.area = AREA_W'(rand64());
      f.m10 = MOM_W'(rand64());
      f.m01 = MOM_W'(rand64());
      f.mu20 = CM_W'(rand64());
      f.mu02 = CM_W'(rand64());
      f.mu11 = XY_W'(rand64());
    end
    return f;
  endfunction

  task automatic queue_frame(input logic [AREA_W-1:0] area, input logic [MOM_W-1:0] m10,
                             input logic [MOM_W-1:0] m01, input logic [CM_W-1:0] mu20,
                             input logic [CM_W-1:0] mu02, input logic signed [XY_W-1:0] mu11);
    frame_moments_t f;
    f.area = area;
    f.m10 = m10;
    f.m01 = m01;
    f.mu20 = mu20;
    f.mu02 = mu02;
    f.mu11 = mu11;
    frames_to_send.push_back(f);
  endtask

  // Waits until every frame has been sent and every shape has come back,
  // then lets the block finish any work still in flight.
  task automatic drain_block();
    while (frames_to_send.size() != 0 || in_bus.valid || shapes_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bound(input logic [ADDR_W-1:0] addr, input logic [AREA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MIN_AREA) bound_lo = value;
    else bound_hi = value;
  endtask

  // Random idling on both sides, except for one long quiet stretch.
  function automatic logic take_break();
    return (cycle_count < 2000 || cycle_count > 3500) && ($urandom_range(0, 99) < 18);
  endfunction

  // Driver: records the expected shape at each accepted transfer and then
  // presents the next pending frame, or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.area_moment <= '0;
      in_bus.x_moment    <= '0;
      in_bus.y_moment    <= '0;
      in_bus.central_xx  <= '0;
      in_bus.central_yy  <= '0;
      in_bus.central_xy  <= '0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (in_bus.valid && in_bus.ready) shapes_due.push_back(shape_of(frame_on_bus));
      if (!in_bus.valid || in_bus.ready) begin
        if (frames_to_send.size() != 0 && !take_break()) begin
          frame_on_bus = frames_to_send.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.area_moment <= frame_on_bus.area;
          in_bus.x_moment    <= frame_on_bus.m10;
          in_bus.y_moment    <= frame_on_bus.m01;
          in_bus.central_xx  <= frame_on_bus.mu20;
          in_bus.central_yy  <= frame_on_bus.mu02;
          in_bus.central_xy  <= frame_on_bus.mu11;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expected shape.
  always @(posedge clk_i or negedge rst_ni) begin
    blob_shape_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !take_break();
      if (out_bus.valid && out_bus.ready) begin
        if (shapes_due.size() == 0) begin
          $display("%0t: result with no frame outstanding", $time);
          errors++;
        end else begin
          want = shapes_due.pop_front();
          if (out_bus.presence !== want.presence) begin
            $display("%0t: presence expected %0d actual %0d", $time, want.presence,
                     out_bus.presence);
            errors++;
          end
          if (out_bus.centroid_x !== want.cx) begin
            $display("%0t: centroid_x expected %0d actual %0d", $time, want.cx,
                     out_bus.centroid_x);
            errors++;
          end
          if (out_bus.centroid_y !== want.cy) begin
            $display("%0t: centroid_y expected %0d actual %0d", $time, want.cy,
                     out_bus.centroid_y);
            errors++;
          end
          if (out_bus.orientation !== want.ori) begin
            $display("%0t: orientation expected %0d actual %0d", $time, want.ori,
                     out_bus.orientation);
            errors++;
          end
          if (out_bus.eccentricity !== want.ecc) begin
            $display("%0t: eccentricity expected %0d actual %0d", $time, want.ecc,
                     out_bus.eccentricity);
            errors++;
          end
          if (out_bus.eccentricity_valid !== want.ecc_ok) begin
            $display("%0t: eccentricity_valid expected %0d actual %0d", $time, want.ecc_ok,
                     out_bus.eccentricity_valid);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset bounds. The first frame has zero area,
    // so the centroid must still read minus one.
    queue_frame(0, 0, 0, 0, 0, 0);
    queue_frame(70000, 70000 * 512, 70000 * 300, 1000, 400, 250);
    queue_frame(70001, 70001 * 1023 + 70000, 0, 400, 1000, -250);
    queue_frame(49999999, 0, 49999999 * 7, 5000, 5000, 17);
    queue_frame(49999999, 0, 49999999 * 7, 5000, 5000, -17);
    queue_frame(50000000, 38'h3f_ffff_ffff, 38'h3f_ffff_ffff, 0, 0, 0);
    queue_frame(0, 38'h3f_ffff_ffff, 12345, 0, 0, 99);
    queue_frame(1, 38'h3f_ffff_ffff, 38'h3f_ffff_ffff, '1, '1, 0);
    queue_frame('1, '1, '1, '1, 0, {1'b1, 46'd0});
    queue_frame('1, 0, 0, 0, '1, {1'b0, {46{1'b1}}});
    queue_frame(100, 3000, 4000, 10, 900, 1);
    queue_frame(100, 3000, 4000, 10, 900, -1);
    queue_frame(100, 3000, 4000, 900, 10, 300);
    queue_frame(100, 3000, 4000, 900, 10, -300);
    queue_frame(100, 3000, 4000, 0, 900, 0);
    queue_frame(5, 5, 5, 0, 0, 1);
    queue_frame(5, 5, 5, 0, 0, -1);
    queue_frame(5, 5, 5, 1, 0, 0);
    queue_frame(0, 1, 1, 3, 3, 3);
    for (int i = 0; i < 100; i++) frames_to_send.push_back(random_frame());
    drain_block();

    // Widest window, then an empty one, then a run of random windows.
    write_bound(ADDR_MIN_AREA, 0);
    write_bound(ADDR_MAX_AREA, '1);
    for (int i = 0; i < 80; i++) frames_to_send.push_back(random_frame());
    drain_block();

    write_bound(ADDR_MIN_AREA, '1);
    write_bound(ADDR_MAX_AREA, 0);
    for (int i = 0; i < 50; i++) frames_to_send.push_back(random_frame());
    drain_block();

    for (int p = 0; p < 4; p++) begin
      write_bound(ADDR_MIN_AREA, AREA_W'(rand_bits(AREA_W)));
      write_bound(ADDR_MAX_AREA, AREA_W'(rand_bits(AREA_W)));
      for (int i = 0; i < 45; i++) frames_to_send.push_back(random_frame());
      drain_block();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
sv/bmsf_pkg.sv
sv/bmsf_if.sv
sv/bmsf_div.sv
sv/blob_moment_shape_features.sv
bench/blob_moment_shape_features_test.sv
